FILE: rtl/core/sut_pkg.sv
// ============================================================================
// sut_pkg - shared types and constants for the sorted key table
// Entry layout, command codes and the control bundle sent to the cell row.
// ============================================================================
`default_nettype none

package sut_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // Field widths
    localparam int KEY_W   = 16;
    localparam int LEN_W   = 16;
    localparam int REM_W   = 17;
    localparam int DUR_W   = 16;
    localparam int ACT_W   = 2;
    localparam int COUNT_OUT_W = 5;

    // Stream widths (tdata padded to whole bytes)
    localparam int S_DATA_W = 56;  // key + length + remaining = 49 bits
    localparam int M_DATA_W = 56;  // start + length + remaining + count = 54 bits
    localparam int S_USER_W = ACT_W;
    localparam int M_USER_W = 2;

    // Command codes
    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SET    = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [REM_W-1:0] rem;
    } t_entry;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;  // latch compare flags against key
        logic             do_ins;  // accepted insert: shift toward tail
        logic             do_rem;  // accepted remove: shift toward head
        logic             do_set;  // accepted set-remaining
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [REM_W-1:0] rem;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/sut_cell.sv
// ============================================================================
// sut_cell - one slot of the sorted table
// Holds one entry, compares it against the broadcast key and takes data
// from either neighbor when the row shifts.
// ============================================================================
`default_nettype none

module sut_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire sut_pkg::t_cell_ctrl i_ctrl,
    input  wire                      i_occupied,  // slot lies below the fill count
    input  wire                      i_prev_lt,   // lower neighbor is below the key
    input  wire sut_pkg::t_entry     i_prev,      // lower neighbor entry
    input  wire sut_pkg::t_entry     i_next,      // upper neighbor entry
    output sut_pkg::t_entry          o_entry,
    output logic                     o_lt,
    output logic                     o_eq
);

    sut_pkg::t_entry r_entry;
    sut_pkg::t_entry n_entry;
    sut_pkg::t_entry w_new;
    logic            r_lt;
    logic            r_eq;

    // Compare flags, latched in the compare phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_lt <= i_occupied && (r_entry.key < i_ctrl.key);
            r_eq <= i_occupied && (r_entry.key == i_ctrl.key);
        end
    end

    // Freshly inserted entry: remaining starts at its length
    always_comb begin
        w_new.key = i_ctrl.key;
        w_new.len = i_ctrl.len;
        w_new.rem = {{(sut_pkg::REM_W-sut_pkg::LEN_W){1'b0}}, i_ctrl.len};
    end

    // Slot update: at or past the insert point shift up, at or past the
    // removed key shift down, matching key takes the new remaining time
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.do_ins && !r_lt) begin
            n_entry = i_prev_lt ? w_new : i_prev;
        end else if (i_ctrl.do_rem && !r_lt) begin
            n_entry = i_next;
        end else if (i_ctrl.do_set && r_eq) begin
            n_entry.rem = i_ctrl.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_unique_key_table_unit.sv
// ============================================================================
// sorted_unique_key_table_unit - sorted table of I/O operations
// Row of cells kept in ascending start-time order with unique keys.
// ============================================================================
// Usage:
//   Commands enter on the s_axis channel, one beat per command; tuser holds
//   the action (insert, remove, set remaining, read first), tdata the key,
//   length and new remaining time. Each command yields exactly one beat on
//   m_axis: accept flag and first-valid flag in tuser, the earliest entry
//   and the entry count in tdata.
//   One command is in work at a time; a new command is taken only once the
//   last result is loaded. Each command goes through these steps in order:
//   accept, compare in every cell, update/shift the cell row, load the
//   output register.
//   The output register holds a beat while m_axis_tready is low; the next
//   command is taken meanwhile, and its result waits in the last phase
//   until the output register frees up.
//   Reset (synchronous, active low) empties the table and clears the task
//   duration to 0, so every insert is rejected until it is written through
//   i_cfg_wen / i_cfg_wdata while the block is idle.
// ============================================================================
`default_nettype none

module sorted_unique_key_table_unit #(
    parameter int TABLE_ENTRIES = sut_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration
    input  wire                           i_cfg_wen,
    input  wire [sut_pkg::DUR_W-1:0]      i_cfg_wdata,     // task duration
    // command stream
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire [sut_pkg::S_DATA_W-1:0]   s_axis_tdata,    // [15:0] start_time,
                                                           // [31:16] io_length,
                                                           // [48:32] remaining_value
    input  wire [sut_pkg::S_USER_W-1:0]   s_axis_tuser,    // [1:0] action
    // result stream
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [sut_pkg::M_DATA_W-1:0]  m_axis_tdata,    // [15:0] first_start,
                                                           // [31:16] first_length,
                                                           // [48:32] first_remaining,
                                                           // [53:49] entry_count
    output logic [sut_pkg::M_USER_W-1:0]  m_axis_tuser     // [0] accepted,
                                                           // [1] first_valid
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_RES  = 4'b1000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [sut_pkg::DUR_W-1:0]     r_dur;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    sut_pkg::t_action              r_act;
    logic [sut_pkg::KEY_W-1:0]     r_key;
    logic [sut_pkg::LEN_W-1:0]     r_len;
    logic [sut_pkg::REM_W-1:0]     r_rem;
    logic                          r_ok;
    logic                          r_m_valid;
    logic [sut_pkg::M_DATA_W-1:0]  r_m_data;
    logic [sut_pkg::M_USER_W-1:0]  r_m_user;

    sut_pkg::t_cell_ctrl           w_ctrl;
    sut_pkg::t_entry               w_entry [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]      w_lt;
    logic [TABLE_ENTRIES-1:0]      w_eq;
    logic                          w_found;
    logic                          w_ins_ok;
    logic                          w_ok;
    logic                          w_s_beat;
    logic                          w_out_free;
    logic                          w_first_valid;
    logic [CW+sut_pkg::COUNT_OUT_W-1:0] w_count_ext;
    sut_pkg::t_entry               w_first;

    assign w_s_beat   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Task duration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= '0;
        end else if (i_cfg_wen) begin
            r_dur <= i_cfg_wdata;
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (w_s_beat) begin
            r_act <= sut_pkg::t_action'(s_axis_tuser[sut_pkg::ACT_W-1:0]);
            r_key <= s_axis_tdata[15:0];
            r_len <= s_axis_tdata[31:16];
            r_rem <= s_axis_tdata[48:32];
        end
    end

    // Decision from the latched cell flags
    assign w_found  = |w_eq;
    assign w_ins_ok = (r_key < r_dur) && !w_found
                      && (r_count < CW'(TABLE_ENTRIES));

    always_comb begin
        w_ctrl.cmp_en = (r_state == ST_CMP);
        w_ctrl.do_ins = 1'b0;
        w_ctrl.do_rem = 1'b0;
        w_ctrl.do_set = 1'b0;
        w_ctrl.key    = r_key;
        w_ctrl.len    = r_len;
        w_ctrl.rem    = r_rem;
        w_ok          = 1'b0;
        n_count       = r_count;
        if (r_state == ST_UPD) begin
            case (r_act)
                sut_pkg::ACT_INSERT: begin
                    w_ok          = w_ins_ok;
                    w_ctrl.do_ins = w_ins_ok;
                    if (w_ins_ok) begin
                        n_count = r_count + CW'(1);
                    end
                end
                sut_pkg::ACT_REMOVE: begin
                    w_ok          = w_found;
                    w_ctrl.do_rem = w_found;
                    if (w_found) begin
                        n_count = r_count - CW'(1);
                    end
                end
                sut_pkg::ACT_SET: begin
                    w_ok          = w_found;
                    w_ctrl.do_set = w_found;
                end
                default: begin
                    w_ok = 1'b0;
                end
            endcase
        end
    end

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            logic            w_occ;
            logic            w_prev_lt;
            sut_pkg::t_entry w_prev;
            sut_pkg::t_entry w_next;

            assign w_occ = (CW'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_prev_lt = 1'b1;
                assign w_prev    = '0;
            end else begin : g_body
                assign w_prev_lt = w_lt[gi-1];
                assign w_prev    = w_entry[gi-1];
            end

            if (gi == TABLE_ENTRIES - 1) begin : g_tail
                assign w_next = w_entry[gi];
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end

            sut_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_occupied (w_occ),
                .i_prev_lt  (w_prev_lt),
                .i_prev     (w_prev),
                .i_next     (w_next),
                .o_entry    (w_entry[gi]),
                .o_lt       (w_lt[gi]),
                .o_eq       (w_eq[gi])
            );
        end
    endgenerate

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_s_beat) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_RES;
            ST_RES:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_UPD) begin
                r_ok <= w_ok;
            end
        end
    end

    // Result beat built from the head cell after the update
    assign w_first_valid = (r_count != '0);
    assign w_count_ext   = {{sut_pkg::COUNT_OUT_W{1'b0}}, r_count};
    assign w_first       = w_first_valid ? w_entry[0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_RES && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RES && w_out_free) begin
            r_m_data <= {2'b00,
                         w_count_ext[sut_pkg::COUNT_OUT_W-1:0],
                         w_first.rem, w_first.len, w_first.key};
            r_m_user <= {w_first_valid, r_ok};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTHESIS
    // Fill count never exceeds the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("fill count beyond table depth");

    // Keys are unique, so at most one cell can match
    a_eq_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_eq))
        else $error("more than one cell matches the key");

    // Cells below the key form a prefix of the row
    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_lt >> 1) & ~w_lt) == '0)
        else $error("table order broken");

    // An accepted insert grows the table by exactly one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.do_ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

    // A result beat appears only out of the result phase
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_RES))
        else $error("result beat without a finished command");
`endif

endmodule

`default_nettype wire

FILE: bench/sorted_unique_key_table_unit_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_unique_key_table_unit_checker - result checker for the key table
// Watches the config port and both stream channels, keeps its own copy of the
// sorted table, predicts one result beat per accepted command and compares
// each result beat field by field against the oldest prediction.
// ============================================================================

module sorted_unique_key_table_unit_checker #(
    parameter int TABLE_DEPTH = sut_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wen,
    input  wire [sut_pkg::DUR_W-1:0]      i_cfg_wdata,
    input  wire                           i_s_tvalid,
    input  wire                           i_s_tready,
    input  wire [sut_pkg::S_DATA_W-1:0]   i_s_tdata,     // [15:0] start_time,
                                                         // [31:16] io_length,
                                                         // [48:32] remaining_value
    input  wire [sut_pkg::S_USER_W-1:0]   i_s_tuser,     // [1:0] action
    input  wire                           i_m_tvalid,
    input  wire                           i_m_tready,
    input  wire [sut_pkg::M_DATA_W-1:0]   i_m_tdata,     // [15:0] first_start,
                                                         // [31:16] first_length,
                                                         // [48:32] first_remaining,
                                                         // [53:49] entry_count
    input  wire [sut_pkg::M_USER_W-1:0]   i_m_tuser,     // [0] accepted,
                                                         // [1] first_valid
    output int                            o_fail_count,
    output int                            o_pending
);

    // What one result beat reports about the table
    typedef struct packed {
        logic                            accepted;
        logic                            first_valid;
        logic [sut_pkg::KEY_W-1:0]       first_start;
        logic [sut_pkg::LEN_W-1:0]       first_length;
        logic [sut_pkg::REM_W-1:0]       first_remaining;
        logic [sut_pkg::COUNT_OUT_W-1:0] entry_count;
    } t_table_view;

    // Shadow table, ascending by key
    logic [sut_pkg::KEY_W-1:0] tbl_key [TABLE_DEPTH];
    logic [sut_pkg::LEN_W-1:0] tbl_len [TABLE_DEPTH];
    logic [sut_pkg::REM_W-1:0] tbl_rem [TABLE_DEPTH];
    int                        tbl_fill;
    logic [sut_pkg::DUR_W-1:0] task_duration;

    t_table_view      view_q[$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    // Apply one command to the shadow table and report the table afterwards
    task automatic apply_command(input sut_pkg::t_action act,
                                 input logic [sut_pkg::KEY_W-1:0] key,
                                 input logic [sut_pkg::LEN_W-1:0] len,
                                 input logic [sut_pkg::REM_W-1:0] rem_v,
                                 output t_table_view view);
        int  pos;
        bit  ok;
        ok  = 1'b0;
        pos = 0;
        case (act)
            sut_pkg::ACT_INSERT: begin
                if (key < task_duration) begin
                    while (pos < tbl_fill && tbl_key[pos] < key)
                        pos++;
                    if (!(pos < tbl_fill && tbl_key[pos] == key) && tbl_fill < TABLE_DEPTH) begin
                        for (int i = tbl_fill; i > pos; i--) begin
                            tbl_key[i] = tbl_key[i-1];
                            tbl_len[i] = tbl_len[i-1];
                            tbl_rem[i] = tbl_rem[i-1];
                        end
                        tbl_key[pos] = key;
                        tbl_len[pos] = len;
                        tbl_rem[pos] = {1'b0, len};
                        tbl_fill++;
                        ok = 1'b1;
                    end
                end
            end
            sut_pkg::ACT_REMOVE, sut_pkg::ACT_SET: begin
                while (pos < tbl_fill && tbl_key[pos] != key)
                    pos++;
                if (pos < tbl_fill) begin
                    ok = 1'b1;
                    if (act == sut_pkg::ACT_SET) begin
                        tbl_rem[pos] = rem_v;
                    end else begin
                        for (int i = pos; i + 1 < tbl_fill; i++) begin
                            tbl_key[i] = tbl_key[i+1];
                            tbl_len[i] = tbl_len[i+1];
                            tbl_rem[i] = tbl_rem[i+1];
                        end
                        tbl_fill--;
                    end
                end
            end
            default: ;  // read first: table untouched
        endcase
        view.accepted    = ok;
        view.first_valid = (tbl_fill > 0);
        if (tbl_fill > 0) begin
            view.first_start     = tbl_key[0];
            view.first_length    = tbl_len[0];
            view.first_remaining = tbl_rem[0];
        end else begin
            view.first_start     = '0;
            view.first_length    = '0;
            view.first_remaining = '0;
        end
        view.entry_count = sut_pkg::COUNT_OUT_W'(tbl_fill);
    endtask

    task automatic compare_field(input string name,
                                 input logic [sut_pkg::REM_W-1:0] want,
                                 input logic [sut_pkg::REM_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Track beats on every edge; results first, since a result never
    // belongs to a command accepted at the same edge
    always @(posedge i_clk) begin
        t_table_view got;
        t_table_view want;
        if (!i_rst_n) begin
            tbl_fill      = 0;
            task_duration = '0;
            view_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.accepted        = i_m_tuser[0];
                got.first_valid     = i_m_tuser[1];
                got.first_start     = i_m_tdata[15:0];
                got.first_length    = i_m_tdata[31:16];
                got.first_remaining = i_m_tdata[48:32];
                got.entry_count     = i_m_tdata[53:49];
                if (view_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = view_q.pop_front();
                    compare_field("accepted", sut_pkg::REM_W'(want.accepted),
                                  sut_pkg::REM_W'(got.accepted));
                    compare_field("first_valid", sut_pkg::REM_W'(want.first_valid),
                                  sut_pkg::REM_W'(got.first_valid));
                    compare_field("first_start", sut_pkg::REM_W'(want.first_start),
                                  sut_pkg::REM_W'(got.first_start));
                    compare_field("first_length", sut_pkg::REM_W'(want.first_length),
                                  sut_pkg::REM_W'(got.first_length));
                    compare_field("first_remaining", want.first_remaining,
                                  got.first_remaining);
                    compare_field("entry_count", sut_pkg::REM_W'(want.entry_count),
                                  sut_pkg::REM_W'(got.entry_count));
                end
            end
            if (i_cfg_wen)
                task_duration = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                apply_command(sut_pkg::t_action'(i_s_tuser), i_s_tdata[15:0],
                              i_s_tdata[31:16], i_s_tdata[48:32], want);
                view_q = {view_q, want};
            end
        end
        o_pending <= view_q.size();
    end

endmodule

FILE: bench/sorted_unique_key_table_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_unique_key_table_unit_tb - testbench top for the sorted key table
// Drives directed and random command sequences with random gaps and output
// stalls, reprograms the task duration between phases, and reports the
// verdict from the checker's mismatch and pending counts.
// ============================================================================

module sorted_unique_key_table_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BEATS    = 212;

    logic                           i_clk;
    logic                           i_rst_n   = 1'b0;
    logic                           cfg_wen   = 1'b0;
    logic [sut_pkg::DUR_W-1:0]      cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_axis_tready;
    logic [sut_pkg::S_DATA_W-1:0]   s_data    = '0;   // [15:0] start_time, [31:16] io_length,
                                                      // [48:32] remaining_value
    logic [sut_pkg::S_USER_W-1:0]   s_user    = '0;   // [1:0] action
    logic                           m_axis_tvalid;
    logic                           m_ready   = 1'b0;
    logic [sut_pkg::M_DATA_W-1:0]   m_axis_tdata;     // [15:0] first_start,
                                                      // [31:16] first_length,
                                                      // [48:32] first_remaining,
                                                      // [53:49] entry_count
    logic [sut_pkg::M_USER_W-1:0]   m_axis_tuser;     // [0] accepted, [1] first_valid

    int                    fail_count;
    int                    pending;
    int                    stall_cycles = 0;
    bit                    no_idle      = 1'b0;
    bit                    rx_hold_req  = 1'b0;

    sorted_unique_key_table_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (cfg_wen),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_unique_key_table_unit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: random stalls per beat, plus one long hold on request
    initial begin
        int hold;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                hold        = LONG_HOLD;
                rx_hold_req = 1'b0;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // One command beat after a random gap; tvalid stays up when the gap is zero
    task automatic send_command(input sut_pkg::t_action act,
                                input logic [sut_pkg::KEY_W-1:0] key,
                                input logic [sut_pkg::LEN_W-1:0] len,
                                input logic [sut_pkg::REM_W-1:0] rem);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'b0, rem, len, key};
        s_user  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_duration(input logic [sut_pkg::DUR_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_wen   <= 1'b0;
    endtask

    // Stimulus
    initial begin
        int                        r;
        int                        ins_weight;
        int                        rest;
        logic [sut_pkg::DUR_W-1:0] dur;
        logic [sut_pkg::KEY_W-1:0] key_base;
        logic [sut_pkg::KEY_W-1:0] key_span;
        logic [sut_pkg::KEY_W-1:0] key;
        sut_pkg::t_action          act;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty read, then the key-range edges under max duration
        send_command(sut_pkg::ACT_READ, 16'h0000, 16'h0000, 17'h00000);
        drain();
        write_duration(16'hFFFF);
        // at duration: rejected
        send_command(sut_pkg::ACT_INSERT, 16'hFFFF, 16'h1234, 17'($urandom));
        // highest key allowed
        send_command(sut_pkg::ACT_INSERT, 16'hFFFE, 16'hFFFF, 17'($urandom));
        // Fill descending so every insert lands at the head
        for (int k = 14; k >= 0; k--)
            send_command(sut_pkg::ACT_INSERT, sut_pkg::KEY_W'(k), 16'($urandom),
                         17'($urandom));
        send_command(sut_pkg::ACT_INSERT, 16'h0010, 16'h0001, 17'h00000);  // table full
        send_command(sut_pkg::ACT_INSERT, 16'h0007, 16'h0002, 17'h00000);  // duplicate key
        send_command(sut_pkg::ACT_SET, 16'h0000, 16'hFFFF, 17'h10000);     // most negative
        send_command(sut_pkg::ACT_SET, 16'h0020, 16'h0000, 17'h0FFFF);     // key absent
        send_command(sut_pkg::ACT_REMOVE, 16'h0000, 16'hFFFF, 17'h1FFFF);
        send_command(sut_pkg::ACT_REMOVE, 16'h0000, 16'h0000, 17'h00000);  // already gone
        drain();
        write_duration(16'h0000);
        // zero duration: rejected
        send_command(sut_pkg::ACT_INSERT, 16'h0000, 16'h0003, 17'h00000);

        // Random phases, each with its own duration and key pool
        for (int phase = 0; phase < 8; phase++) begin
            ins_weight = 40;
            no_idle    = (phase == 1 || phase == 6);
            case (phase)
                0: begin dur = 16'hFFFF; key_base = 16'd0; key_span = 16'd23;
                         ins_weight = 50; end
                1: begin dur = 16'd32; key_base = 16'd0; key_span = 16'd40; end
                2: begin dur = 16'd1; key_base = 16'd0; key_span = 16'd3; end
                3: begin dur = 16'($urandom_range(16, 65535));
                         key_base = 16'($urandom_range(0, 65500)); key_span = 16'd31; end
                4: begin dur = 16'hFFFF; key_base = 16'd65512; key_span = 16'd23; end
                5: begin dur = 16'd20; key_base = 16'd0; key_span = 16'd23;
                         ins_weight = 25; end
                6: begin dur = 16'($urandom_range(2, 65535)); key_base = 16'd0;
                         key_span = 16'd63; end
                default: begin dur = 16'hFFFF; key_base = 16'd100; key_span = 16'd19;
                               ins_weight = 70; end
            endcase
            drain();
            write_duration(dur);
            // Back up the result side once while commands keep coming
            if (phase == 3)
                rx_hold_req = 1'b1;
            rest = 100 - ins_weight;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (n == PHASE_BEATS / 2)
                    drain();
                r = $urandom_range(0, 99);
                if (r < ins_weight)
                    act = sut_pkg::ACT_INSERT;
                else if (r < ins_weight + rest * 45 / 100)
                    act = sut_pkg::ACT_REMOVE;
                else if (r < ins_weight + rest * 80 / 100)
                    act = sut_pkg::ACT_SET;
                else
                    act = sut_pkg::ACT_READ;
                // Mostly pool keys; some fully random, some right at the duration edge
                r = $urandom_range(0, 99);
                if (r < 8)
                    key = 16'($urandom_range(0, 65535));
                else if (r < 12)
                    key = dur - 16'($urandom_range(0, 1));
                else
                    key = key_base + 16'($urandom_range(0, key_span));
                send_command(act, key, 16'($urandom), 17'($urandom));
            end
        end

        drain();
        no_idle = 1'b0;
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sut_pkg.sv
rtl/core/sut_cell.sv
rtl/core/sorted_unique_key_table_unit.sv
bench/sorted_unique_key_table_unit_checker.sv
bench/sorted_unique_key_table_unit_tb.sv
